// ===== hdl/buffer_energy_current_limiter_macros.svh =====
// Assertion macros shared by the checker of the buffer energy current limiter.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef BUFFER_ENERGY_CURRENT_LIMITER_MACROS_SVH
`define BUFFER_ENERGY_CURRENT_LIMITER_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define BEL_ASSERT_SAME(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define BEL_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== hdl/bel_pkg.sv =====
// Package of the buffer energy current limiter: widths, constants, item types.
// Used by every module of the block; depends on nothing.
package bel_pkg;

    // Lane count and field widths.
    localparam int MOTOR_LANES = 4;
    localparam int CUR_W       = 16;
    localparam int MAG_W       = 16;
    localparam int BUF_W       = 10;
    localparam int BUDGET_W    = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 1;

    // Buffer energy thresholds and the fixed-point denominator (60 * 60).
    localparam int BUF_CLAMP = 60;
    localparam int BUF_KNEE  = 25;
    localparam int SCALE_DEN = BUF_CLAMP * BUF_CLAMP;
    localparam int BCL_W     = $clog2(BUF_CLAMP + 1);
    localparam int FACT_W    = $clog2(SCALE_DEN + 1);
    localparam int LIM_W     = BUDGET_W + FACT_W;

    // Pipeline layout: front stages, one stage per quotient bit, output register.
    localparam int QUOT_W       = MAG_W;
    localparam int FRONT_STAGES = 3;
    localparam int PIPE_STAGES  = FRONT_STAGES + QUOT_W + 1;

    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 16'd32000;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIMIT_ENABLE = 1'b0,
        CFG_TOTAL_BUDGET = 1'b1
    } cfg_idx_t;

    // Input item.
    typedef struct packed {
        logic signed [CUR_W-1:0] current_front_left;
        logic signed [CUR_W-1:0] current_front_right;
        logic signed [CUR_W-1:0] current_back_left;
        logic signed [CUR_W-1:0] current_back_right;
        logic [BUF_W-1:0]        buffer_energy;
    } cmd_t;

    // Result item.
    typedef struct packed {
        logic signed [CUR_W-1:0] limited_front_left;
        logic signed [CUR_W-1:0] limited_front_right;
        logic signed [CUR_W-1:0] limited_back_left;
        logic signed [CUR_W-1:0] limited_back_right;
        logic                    was_scaled;
    } res_t;

    // Per-item decisions that travel beside the lane dividers.
    typedef struct packed {
        logic limit_on;
        logic sum_zero;
        logic reached;
    } flags_t;

endpackage

// ===== hdl/bel_stream_if.sv =====
// Valid/ready stream interface carrying one item of a given type.
// No dependencies; the item type is set where the interface is instantiated.
interface bel_stream_if #(
    parameter type item_t = logic
) ();
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/buffer_energy_current_limiter.sv =====
// Top level of the buffer energy current limiter: configuration registers,
// pipeline flow control, lane dividers and the output merge. Uses bel_pkg,
// bel_stream_if, bel_front and bel_div_lane.
//
// Usage:
//   cmd carries one item: four signed motor currents and the buffer energy.
//   res carries one item per input: the four limited currents and was_scaled.
//   Both channels move an item on a clock edge with valid and ready high.
//   cfg_we/cfg_idx/cfg_wdata write limit_enable (index 0) and
//   total_current_budget (index 1); write them only while no item is in flight.
//   res.valid rises once the item has passed the three front stages
//   (magnitudes and factor, sums, multipliers), 16 divider stages (one per
//   quotient bit) and the output register; 20 register stages in all.
//   Throughput is one item per cycle while res.ready stays high; the four
//   lanes divide in parallel. When res.ready is low, the output register
//   holds its item and each stage holds only if the stage after it is full,
//   so empty slots still fill and cmd.ready drops once the pipeline is packed.
//   Reset clears all stage valid bits, clears limit_enable and sets the
//   budget to 32000.
module buffer_energy_current_limiter #(
    parameter int MOTOR_LANES = bel_pkg::MOTOR_LANES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bel_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [bel_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    bel_stream_if.sink                        cmd,
    bel_stream_if.source                      res
);
    import bel_pkg::*;

    localparam int SUM_W = MAG_W + $clog2(MOTOR_LANES);
    localparam int DEN_W = SUM_W + FACT_W;
    localparam int NUM_W = MAG_W + LIM_W;
    localparam int LAST  = PIPE_STAGES - 1;

    logic                    limit_enable_reg;
    logic [BUDGET_W-1:0]     budget_reg;
    logic [PIPE_STAGES-1:0]  valid_reg, valid_next;
    logic [PIPE_STAGES-1:0]  stage_en;

    logic signed [CUR_W-1:0] cmd_cur [MOTOR_LANES];
    logic signed [CUR_W-1:0] front_cur [MOTOR_LANES];
    logic [NUM_W-1:0]        front_num [MOTOR_LANES];
    logic [DEN_W-1:0]        front_den;
    flags_t                  front_flags;
    flags_t                  flags_reg [QUOT_W];

    logic signed [CUR_W-1:0] lane_cur [MOTOR_LANES];
    logic [QUOT_W-1:0]       lane_quo [MOTOR_LANES];
    logic signed [CUR_W-1:0] lane_res [MOTOR_LANES];
    res_t                    res_reg, res_next;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_enable_reg <= 1'b0;
            budget_reg       <= BUDGET_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_idx))
                CFG_LIMIT_ENABLE: limit_enable_reg <= cfg_wdata[0];
                CFG_TOTAL_BUDGET: budget_reg       <= cfg_wdata[BUDGET_W-1:0];
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or the stage after it loads.
    assign stage_en[LAST] = !valid_reg[LAST] || res.ready;
    for (genvar k = 0; k < LAST; k++)
    begin : g_flow
        assign stage_en[k] = !valid_reg[k] || stage_en[k+1];
    end

    assign valid_next = {valid_reg[LAST-1:0], cmd.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < PIPE_STAGES; k++)
            begin
                if (stage_en[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    assign cmd.ready = stage_en[0];
    assign res.valid = valid_reg[LAST];
    assign res.data  = res_reg;

    // Input currents as a lane array.
    assign cmd_cur[0] = cmd.data.current_front_left;
    assign cmd_cur[1] = cmd.data.current_front_right;
    assign cmd_cur[2] = cmd.data.current_back_left;
    assign cmd_cur[3] = cmd.data.current_back_right;

    bel_front #(
        .MOTOR_LANES (MOTOR_LANES),
        .SUM_W       (SUM_W),
        .DEN_W       (DEN_W),
        .NUM_W       (NUM_W)
    ) u_front (
        .clk          (clk),
        .stage_en     (stage_en[FRONT_STAGES-1:0]),
        .cur_in       (cmd_cur),
        .buf_in       (cmd.data.buffer_energy),
        .limit_enable (limit_enable_reg),
        .budget       (budget_reg),
        .cur_out      (front_cur),
        .num_out      (front_num),
        .den_out      (front_den),
        .flags        (front_flags)
    );

    // Lane dividers compute magnitude * allowed / (3600 * sum) in parallel.
    for (genvar i = 0; i < MOTOR_LANES; i++)
    begin : g_lane
        bel_div_lane #(
            .NUM_W (NUM_W),
            .DEN_W (DEN_W)
        ) u_lane (
            .clk      (clk),
            .stage_en (stage_en[FRONT_STAGES +: QUOT_W]),
            .cur_in   (front_cur[i]),
            .num_in   (front_num[i]),
            .den_in   (front_den),
            .cur_out  (lane_cur[i]),
            .quo_out  (lane_quo[i])
        );
    end

    // Decision flags travel alongside the divider stages.
    for (genvar j = 0; j < QUOT_W; j++)
    begin : g_flags
        always_ff @(posedge clk)
        begin
            if (stage_en[FRONT_STAGES + j])
            begin
                flags_reg[j] <= (j == 0) ? front_flags : flags_reg[(j == 0) ? 0 : j - 1];
            end
        end
    end

    // Merge: pass through, zero, or the signed quotient, per the item's flags.
    always_comb
    begin
        flags_t                 f;
        logic signed [QUOT_W:0] q_wide;
        logic signed [QUOT_W:0] q_neg;
        f = flags_reg[QUOT_W-1];
        for (int i = 0; i < MOTOR_LANES; i++)
        begin
            q_wide = {1'b0, lane_quo[i]};
            q_neg  = -q_wide;
            if (!f.limit_on)
            begin
                lane_res[i] = lane_cur[i];
            end
            else if (f.sum_zero)
            begin
                lane_res[i] = '0;
            end
            else if (f.reached)
            begin
                lane_res[i] = lane_cur[i][CUR_W-1] ? q_neg[CUR_W-1:0] : q_wide[CUR_W-1:0];
            end
            else
            begin
                lane_res[i] = lane_cur[i];
            end
        end
        res_next.limited_front_left  = lane_res[0];
        res_next.limited_front_right = lane_res[1];
        res_next.limited_back_left   = lane_res[2];
        res_next.limited_back_right  = lane_res[3];
        res_next.was_scaled          = f.limit_on && f.reached;
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (stage_en[LAST])
        begin
            res_reg <= res_next;
        end
    end

endmodule

// ===== hdl/bel_front.sv =====
// Front pipeline of the limiter: magnitudes, budget factor, sum, allowed total,
// and the numerators and denominator for the lane dividers. Uses bel_pkg.
module bel_front #(
    parameter int MOTOR_LANES = bel_pkg::MOTOR_LANES,
    parameter int SUM_W       = bel_pkg::MAG_W + $clog2(bel_pkg::MOTOR_LANES),
    parameter int DEN_W       = SUM_W + bel_pkg::FACT_W,
    parameter int NUM_W       = bel_pkg::MAG_W + bel_pkg::LIM_W
) (
    input  logic                                clk,
    input  logic [bel_pkg::FRONT_STAGES-1:0]    stage_en,
    input  logic signed [bel_pkg::CUR_W-1:0]    cur_in [MOTOR_LANES],
    input  logic [bel_pkg::BUF_W-1:0]           buf_in,
    input  logic                                limit_enable,
    input  logic [bel_pkg::BUDGET_W-1:0]        budget,
    output logic signed [bel_pkg::CUR_W-1:0]    cur_out [MOTOR_LANES],
    output logic [NUM_W-1:0]                    num_out [MOTOR_LANES],
    output logic [DEN_W-1:0]                    den_out,
    output bel_pkg::flags_t                     flags
);
    import bel_pkg::*;

    // Stage 1 registers.
    logic signed [CUR_W-1:0] cur1_reg [MOTOR_LANES];
    logic [MAG_W-1:0]        mag1_reg [MOTOR_LANES];
    logic [MAG_W-1:0]        mag1_next [MOTOR_LANES];
    logic [FACT_W-1:0]       fact1_reg, fact1_next;
    logic                    on1_reg;
    logic [BCL_W-1:0]        buf_clamped;

    // Stage 2 registers.
    logic signed [CUR_W-1:0] cur2_reg [MOTOR_LANES];
    logic [MAG_W-1:0]        mag2_reg [MOTOR_LANES];
    logic [SUM_W-1:0]        sum2_reg, sum2_next;
    logic [LIM_W-1:0]        lim2_reg, lim2_next;
    logic                    on2_reg;

    // Stage 3 registers.
    logic signed [CUR_W-1:0] cur3_reg [MOTOR_LANES];
    logic [NUM_W-1:0]        num3_reg [MOTOR_LANES];
    logic [NUM_W-1:0]        num3_next [MOTOR_LANES];
    logic [DEN_W-1:0]        den3_reg, den3_next;
    logic [LIM_W-1:0]        lim3_reg;
    logic                    zero3_reg;
    logic                    on3_reg;

    // Magnitudes of the signed currents; the most negative value maps to 2^15.
    always_comb
    begin
        logic signed [CUR_W:0] wide;
        logic signed [CUR_W:0] absval;
        for (int i = 0; i < MOTOR_LANES; i++)
        begin
            wide         = {cur_in[i][CUR_W-1], cur_in[i]};
            absval       = wide[CUR_W] ? -wide : wide;
            mag1_next[i] = absval[MAG_W-1:0];
        end
    end

    // Budget factor in units of 1/3600: 3600, buffer*60 from the knee up, buffer^2 below.
    assign buf_clamped = (buf_in > BUF_W'(BUF_CLAMP)) ? BCL_W'(BUF_CLAMP)
                                                      : buf_in[BCL_W-1:0];
    always_comb
    begin
        if (buf_clamped == BCL_W'(BUF_CLAMP))
        begin
            fact1_next = FACT_W'(SCALE_DEN);
        end
        else if (buf_clamped >= BCL_W'(BUF_KNEE))
        begin
            fact1_next = FACT_W'(FACT_W'(buf_clamped) * FACT_W'(BUF_CLAMP));
        end
        else
        begin
            fact1_next = FACT_W'(FACT_W'(buf_clamped) * FACT_W'(buf_clamped));
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            cur1_reg  <= cur_in;
            mag1_reg  <= mag1_next;
            fact1_reg <= fact1_next;
            on1_reg   <= limit_enable;
        end
    end

    // Stage 2: total magnitude and allowed total scaled by 3600.
    always_comb
    begin
        sum2_next = '0;
        for (int i = 0; i < MOTOR_LANES; i++)
        begin
            sum2_next = sum2_next + SUM_W'(mag1_reg[i]);
        end
    end
    assign lim2_next = LIM_W'(budget) * LIM_W'(fact1_reg);

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            cur2_reg <= cur1_reg;
            mag2_reg <= mag1_reg;
            sum2_reg <= sum2_next;
            lim2_reg <= lim2_next;
            on2_reg  <= on1_reg;
        end
    end

    // Stage 3: per-lane numerator magnitude * allowed, common denominator sum * 3600.
    always_comb
    begin
        for (int i = 0; i < MOTOR_LANES; i++)
        begin
            num3_next[i] = NUM_W'(mag2_reg[i]) * NUM_W'(lim2_reg);
        end
    end
    assign den3_next = DEN_W'(sum2_reg) * DEN_W'(SCALE_DEN);

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            cur3_reg  <= cur2_reg;
            num3_reg  <= num3_next;
            den3_reg  <= den3_next;
            lim3_reg  <= lim2_reg;
            zero3_reg <= (sum2_reg == '0);
            on3_reg   <= on2_reg;
        end
    end

    // The budget is reached when sum * 3600 is at least the allowed total times 3600.
    assign cur_out        = cur3_reg;
    assign num_out        = num3_reg;
    assign den_out        = den3_reg;
    assign flags.limit_on = on3_reg;
    assign flags.sum_zero = zero3_reg;
    assign flags.reached  = (den3_reg >= DEN_W'(lim3_reg));

endmodule

// ===== hdl/bel_div_lane.sv =====
// One lane divider: a pipelined restoring divider that yields one quotient bit
// per stage, carrying the lane's original current alongside. Uses bel_pkg.
module bel_div_lane #(
    parameter int NUM_W = bel_pkg::MAG_W + bel_pkg::LIM_W,
    parameter int DEN_W = bel_pkg::MAG_W + 2 + bel_pkg::FACT_W
) (
    input  logic                             clk,
    input  logic [bel_pkg::QUOT_W-1:0]       stage_en,
    input  logic signed [bel_pkg::CUR_W-1:0] cur_in,
    input  logic [NUM_W-1:0]                 num_in,
    input  logic [DEN_W-1:0]                 den_in,
    output logic signed [bel_pkg::CUR_W-1:0] cur_out,
    output logic [bel_pkg::QUOT_W-1:0]       quo_out
);
    import bel_pkg::*;

    localparam int REM_W = DEN_W + QUOT_W;

    logic [REM_W-1:0]        rem_reg [QUOT_W];
    logic [DEN_W-1:0]        den_reg [QUOT_W];
    logic [QUOT_W-1:0]       quo_reg [QUOT_W];
    logic signed [CUR_W-1:0] cur_reg [QUOT_W];

    for (genvar j = 0; j < QUOT_W; j++)
    begin : g_stage
        localparam int SHIFT = QUOT_W - 1 - j;

        logic [REM_W-1:0]        rem_prev, rem_next, trial;
        logic [DEN_W-1:0]        den_prev;
        logic [QUOT_W-1:0]       quo_prev, quo_next;
        logic signed [CUR_W-1:0] cur_prev;

        if (j == 0)
        begin : g_first
            assign rem_prev = REM_W'(num_in);
            assign den_prev = den_in;
            assign quo_prev = '0;
            assign cur_prev = cur_in;
        end
        else
        begin : g_later
            assign rem_prev = rem_reg[j-1];
            assign den_prev = den_reg[j-1];
            assign quo_prev = quo_reg[j-1];
            assign cur_prev = cur_reg[j-1];
        end

        // Subtract the shifted divisor when it fits and set this quotient bit.
        assign trial = REM_W'(den_prev) << SHIFT;
        always_comb
        begin
            if (rem_prev >= trial)
            begin
                rem_next = rem_prev - trial;
                quo_next = quo_prev | (QUOT_W'(1) << SHIFT);
            end
            else
            begin
                rem_next = rem_prev;
                quo_next = quo_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_en[j])
            begin
                rem_reg[j] <= rem_next;
                den_reg[j] <= den_prev;
                quo_reg[j] <= quo_next;
                cur_reg[j] <= cur_prev;
            end
        end
    end

    assign cur_out = cur_reg[QUOT_W-1];
    assign quo_out = quo_reg[QUOT_W-1];

endmodule

// ===== hdl/bel_checker.sv =====
// Port-level checker for the buffer energy current limiter, with its bind.
// Uses bel_pkg and the assertion macros header.
`include "buffer_energy_current_limiter_macros.svh"

module bel_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          cmd_valid,
    input logic          cmd_ready,
    input logic          res_valid,
    input logic          res_ready,
    input bel_pkg::res_t res_data
);
    import bel_pkg::*;

    // A waiting result stays offered until it is taken.
    `BEL_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")

    // A stalled result does not change.
    `BEL_ASSERT_NEXT(a_res_stable, res_valid && !res_ready, $stable(res_data), "stalled result changed")

    // With the output register empty, the pipeline can always take an item.
    `BEL_ASSERT_SAME(a_ready_when_empty, !res_valid, cmd_ready, "input not ready with empty output")

    // When the receiver takes the output, every stage can advance.
    `BEL_ASSERT_SAME(a_ready_when_drained, res_ready, cmd_ready, "input not ready while output drains")

endmodule

bind buffer_energy_current_limiter bel_checker u_bel_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_data  (res.data)
);

// ===== tb/buffer_energy_current_limiter_test.sv =====
// Self-checking testbench for buffer_energy_current_limiter: random handshakes on both
// streams, register writes between phases, and a scoreboard that predicts each result.
// Depends on bel_pkg, bel_stream_if and the top level of the block.
module buffer_energy_current_limiter_test;
    import bel_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 210;
    localparam int RANDOM_PHASES  = 6;

    // Predicts the limited currents and keeps the results still owed by the block.
    class limiter_scoreboard;
        bit                  limit_on;
        logic [BUDGET_W-1:0] budget;
        res_t                pending_limited[$];
        int unsigned         mismatch_count;
        int unsigned         checked_count;

        function new();
            limit_on       = 1'b0;
            budget         = BUDGET_RESET;
            mismatch_count = 0;
            checked_count  = 0;
        endfunction

        // Scales the four currents by allowed / sum when the sum reaches the allowed total.
        function res_t limit_currents(cmd_t c);
            logic signed [CUR_W-1:0] lane [MOTOR_LANES];
            logic signed [CUR_W-1:0] lane_out [MOTOR_LANES];
            longint mag [MOTOR_LANES];
            longint sum;
            longint energy;
            longint budget_wide;
            longint allowed;
            longint q;
            bit reached;
            res_t r;

            lane = '{c.current_front_left, c.current_front_right,
                     c.current_back_left, c.current_back_right};
            sum = 0;
            for (int i = 0; i < MOTOR_LANES; i++)
            begin
                mag[i] = (lane[i] < 0) ? -longint'(lane[i]) : longint'(lane[i]);
                sum += mag[i];
            end

            // The allowed total is kept as a numerator over 3600 so nothing rounds early.
            energy      = c.buffer_energy;
            budget_wide = budget;
            if (energy > BUF_CLAMP)
                energy = BUF_CLAMP;
            if (energy >= BUF_CLAMP)
                allowed = budget_wide * SCALE_DEN;
            else if (energy >= BUF_KNEE)
                allowed = budget_wide * energy * BUF_CLAMP;
            else
                allowed = budget_wide * energy * energy;
            reached = limit_on && (sum * SCALE_DEN >= allowed);

            for (int i = 0; i < MOTOR_LANES; i++)
            begin
                if (!limit_on)
                    lane_out[i] = lane[i];
                else if (sum == 0)
                    lane_out[i] = '0;
                else if (reached)
                begin
                    q = (mag[i] * allowed) / (SCALE_DEN * sum);
                    lane_out[i] = CUR_W'((lane[i] < 0) ? -q : q);
                end
                else
                    lane_out[i] = lane[i];
            end

            r.limited_front_left  = lane_out[0];
            r.limited_front_right = lane_out[1];
            r.limited_back_left   = lane_out[2];
            r.limited_back_right  = lane_out[3];
            r.was_scaled          = reached;
            return r;
        endfunction

        function void note_cmd(cmd_t c);
            pending_limited.push_back(limit_currents(c));
        endfunction

        // Compares one result item field by field with the oldest prediction.
        function void check_res(res_t got);
            res_t want;
            logic signed [CUR_W-1:0] want_lane [MOTOR_LANES];
            logic signed [CUR_W-1:0] got_lane [MOTOR_LANES];
            string lane_name [MOTOR_LANES];

            lane_name = '{"limited_front_left", "limited_front_right",
                          "limited_back_left", "limited_back_right"};
            checked_count++;
            if (pending_limited.size() == 0)
            begin
                $display("%0t: result item with no prediction pending", $time);
                mismatch_count++;
                return;
            end
            want = pending_limited.pop_front();
            want_lane = '{want.limited_front_left, want.limited_front_right,
                          want.limited_back_left, want.limited_back_right};
            got_lane  = '{got.limited_front_left, got.limited_front_right,
                          got.limited_back_left, got.limited_back_right};
            for (int i = 0; i < MOTOR_LANES; i++)
            begin
                if (got_lane[i] !== want_lane[i])
                begin
                    $display("%0t: %s expected %0d, actual %0d",
                             $time, lane_name[i], want_lane[i], got_lane[i]);
                    mismatch_count++;
                end
            end
            if (got.was_scaled !== want.was_scaled)
            begin
                $display("%0t: was_scaled expected %0b, actual %0b",
                         $time, want.was_scaled, got.was_scaled);
                mismatch_count++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_idx_t              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    bit                    steady;
    int unsigned           sent_count;
    int unsigned           stall_cycles;
    limiter_scoreboard     board;

    bel_stream_if #(.item_t(cmd_t)) cmd_ch ();
    bel_stream_if #(.item_t(res_t)) res_ch ();

    buffer_energy_current_limiter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .res       (res_ch)
    );

    always #1 clk = ~clk;

    // The result side stalls at random except during the steady phase.
    always @(posedge clk)
        res_ch.ready <= steady || ($urandom_range(0, 99) >= 27);

    // Record every accepted command and check every accepted result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
                board.note_cmd(cmd_ch.data);
            if (res_ch.valid && res_ch.ready)
                board.check_res(res_ch.data);
        end
    end

    // End the run when no item moves on either stream for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic cmd_t pack_cmd(int fl, int fr, int bl, int br, int energy);
        cmd_t c;
        c.current_front_left  = CUR_W'(fl);
        c.current_front_right = CUR_W'(fr);
        c.current_back_left   = CUR_W'(bl);
        c.current_back_right  = CUR_W'(br);
        c.buffer_energy       = BUF_W'(energy);
        return c;
    endfunction

    // Mix of full-range, small, medium and extreme current commands.
    function automatic int random_current();
        int v;
        case ($urandom_range(0, 4))
            0: v = int'($urandom_range(0, 65535)) - 32768;
            1: v = int'($urandom_range(0, 2000)) - 1000;
            2: v = int'($urandom_range(0, 16000)) - 8000;
            3:
            begin
                case ($urandom_range(0, 4))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = -1;
                    3: v = 1;
                    default: v = 0;
                endcase
            end
            default: v = int'($urandom_range(0, 130)) - 65;
        endcase
        return v;
    endfunction

    function automatic cmd_t random_cmd();
        int energy;
        case ($urandom_range(0, 3))
            0: energy = $urandom_range(0, BUF_KNEE - 1);
            1: energy = $urandom_range(BUF_KNEE, BUF_CLAMP);
            2: energy = $urandom_range(0, 1023);
            default:
            begin
                case ($urandom_range(0, 5))
                    0: energy = 0;
                    1: energy = BUF_KNEE - 1;
                    2: energy = BUF_KNEE;
                    3: energy = BUF_CLAMP - 1;
                    4: energy = BUF_CLAMP;
                    default: energy = BUF_CLAMP + 1;
                endcase
            end
        endcase
        // An all-zero command now and then reaches the zero-sum case.
        if ($urandom_range(0, 19) == 0)
            return pack_cmd(0, 0, 0, 0, energy);
        return pack_cmd(random_current(), random_current(), random_current(),
                        random_current(), energy);
    endfunction

    // Offer one command, idling at random first, and return once it is accepted.
    task automatic send_cmd(input cmd_t c);
        while (!steady && $urandom_range(0, 99) < 27)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        sent_count++;
    endtask

    // Stop sending and wait until every command sent has produced its result.
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        while (board.checked_count < sent_count)
            @(posedge clk);
    endtask

    // Register writes happen only while the pipeline is empty.
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_LIMIT_ENABLE)
            board.limit_on = value[0];
        else
            board.budget = value;
        @(posedge clk);
    endtask

    initial
    begin
        int phase;
        int n;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = CFG_LIMIT_ENABLE;
        cfg_wdata    = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        steady       = 1'b0;
        sent_count   = 0;
        board        = new();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Limiting is off after reset, so the extremes pass straight through.
        send_cmd(pack_cmd(32767, -32768, 0, -1, 0));
        send_cmd(pack_cmd(-32768, -32768, 32767, 1, 1023));
        wait_drained();

        // Full budget: each branch of the allowed total and its boundaries.
        write_reg(CFG_LIMIT_ENABLE, 16'd1);
        write_reg(CFG_TOTAL_BUDGET, 16'd32000);
        send_cmd(pack_cmd(8000, -8000, 8000, -8000, 60));
        send_cmd(pack_cmd(8000, 8000, 8000, 7999, 60));
        send_cmd(pack_cmd(-32768, -32768, -32768, -32768, 1023));
        send_cmd(pack_cmd(32767, 32767, 32767, 32767, 61));
        send_cmd(pack_cmd(10000, -3000, 2500, -20000, 59));
        send_cmd(pack_cmd(5000, 5000, -5000, 5000, 25));
        send_cmd(pack_cmd(1280, -1280, 1280, -1280, 24));
        send_cmd(pack_cmd(0, 0, 0, 0, 0));
        send_cmd(pack_cmd(0, 0, 0, 0, 30));
        send_cmd(pack_cmd(1, -1, 0, 0, 1));
        send_cmd(pack_cmd(1, -32768, 32767, -1, 0));
        wait_drained();

        // A zero budget forces every nonzero command down to zero.
        write_reg(CFG_TOTAL_BUDGET, 16'd0);
        send_cmd(pack_cmd(0, 0, 0, 0, 60));
        send_cmd(pack_cmd(-12345, 23456, -7, 300, 45));
        wait_drained();

        write_reg(CFG_TOTAL_BUDGET, 16'hFFFF);
        send_cmd(pack_cmd(-32768, -32768, -32768, -32768, 60));
        send_cmd(pack_cmd(32767, 32767, 32767, -32768, 512));

        // Random phases, each under its own register setting.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_drained();
            case (phase)
                0:
                begin
                    write_reg(CFG_LIMIT_ENABLE, 16'd1);
                    write_reg(CFG_TOTAL_BUDGET, CFG_DATA_W'($urandom_range(0, 65535)));
                end
                1: write_reg(CFG_TOTAL_BUDGET, 16'hFFFF);
                2: write_reg(CFG_TOTAL_BUDGET, CFG_DATA_W'($urandom_range(1, 200)));
                3: write_reg(CFG_TOTAL_BUDGET, 16'd32000);
                4:
                begin
                    write_reg(CFG_LIMIT_ENABLE, 16'd0);
                    write_reg(CFG_TOTAL_BUDGET, CFG_DATA_W'($urandom_range(0, 65535)));
                end
                default:
                begin
                    write_reg(CFG_LIMIT_ENABLE, 16'd1);
                    write_reg(CFG_TOTAL_BUDGET, 16'd0);
                end
            endcase
            steady = (phase == 3);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // Occasionally let the pipeline empty completely mid-phase.
                if ($urandom_range(0, 63) == 0)
                    wait_drained();
                send_cmd(random_cmd());
            end
        end

        wait_drained();
        repeat (PIPE_STAGES + 4) @(posedge clk);
        if (board.pending_limited.size() != 0)
        begin
            $display("%0t: %0d predicted results never arrived",
                     $time, board.pending_limited.size());
            board.mismatch_count++;
        end
        if (board.mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/bel_pkg.sv
hdl/bel_stream_if.sv
hdl/bel_front.sv
hdl/bel_div_lane.sv
hdl/buffer_energy_current_limiter.sv
hdl/bel_checker.sv
tb/buffer_energy_current_limiter_test.sv
